FILE: src/assert_macros.svh
// assertion macros used by the checker file tcw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define TCW_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/tcw_pkg.sv
package tcw_pkg;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int CELLS     = ROWS * COLUMNS;
	localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int SCAN_W = $clog2(CELLS + 1);
	localparam int CHAR_W = 8;
	localparam int CELL_W = 2 * CHAR_W;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int LIN_W  = ADDR_W + ROW_W;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'd7;
	localparam logic [CELL_W-1:0] CLEAR_CELL   = {RESET_COLOR, SPACE_CODE};

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
		logic              end_of_string;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              scrolled;
		logic              write_done;
	} result_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [LIN_W-1:0] lin;
		lin = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
		return lin[ADDR_W-1:0];
	endfunction

endpackage

FILE: src/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/text_console_writer_top.sv
// channel   direction  handshake             payload
// command   in         start && !busy        item (tcw_pkg::item_t)
// result    out        done, one cycle       result (tcw_pkg::result_t)
// config    in         cfg_valid && cfg_ready cfg_data (text color)
//
// an item that does not scroll (put, newline or read) passes ST_EXEC, then ST_FINISH;
// the next start is taken in the cycle that shows done
// a scroll adds one pass of the screen ram, one cell per cycle
// after reset the ram is filled with grey spaces while busy stays high
// results cannot be stalled; done is high for exactly one cycle per item
module text_console_writer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  tcw_pkg::item_t               item,
	output logic                         done,
	output tcw_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcw_pkg::CHAR_W-1:0]   cfg_data
);

	tcw_pkg::state_t                  state_q, state_d;
	tcw_pkg::item_t                   item_q, item_d;
	logic [tcw_pkg::ROW_W-1:0]        cur_row_q, cur_row_d;
	logic [tcw_pkg::COL_W-1:0]        cur_col_q, cur_col_d;
	logic [tcw_pkg::CHAR_W-1:0]       color_q;
	logic [tcw_pkg::SCAN_W-1:0]       scan_q, scan_d;
	logic                             pend_q, pend_d;
	logic                             pend_zero_q, pend_zero_d;
	logic [tcw_pkg::ADDR_W-1:0]       pend_addr_q, pend_addr_d;
	logic                             scrolled_q, scrolled_d;
	logic                             cell_ok_q, cell_ok_d;

	logic                             ram_we;
	logic [tcw_pkg::ADDR_W-1:0]       ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]       ram_wdata;
	logic                             ram_re;
	logic [tcw_pkg::ADDR_W-1:0]       ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]       ram_rdata;

	logic [tcw_pkg::COL_W:0]          col_next;
	logic                             col_wrap;
	logic                             at_bottom;
	logic                             rd_in_range;
	logic                             new_row;
	logic [tcw_pkg::SCAN_W-1:0]       src_scan;

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign col_next  = {1'b0, cur_col_q} + (tcw_pkg::COL_W + 1)'(1);
	assign col_wrap  = col_next == (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS);
	assign at_bottom = cur_row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	assign src_scan  = scan_q + tcw_pkg::SCAN_W'(tcw_pkg::COLUMNS);
	assign rd_in_range = (32'(item_q.read_row) < tcw_pkg::ROWS)
		&& (32'(item_q.read_col) < tcw_pkg::COLUMNS);

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		cur_row_d   = cur_row_q;
		cur_col_d   = cur_col_q;
		scan_d      = scan_q;
		pend_d      = pend_q;
		pend_zero_d = pend_zero_q;
		pend_addr_d = pend_addr_q;
		scrolled_d  = scrolled_q;
		cell_ok_d   = cell_ok_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		new_row     = 1'b0;

		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q[tcw_pkg::ADDR_W-1:0];
				ram_wdata = tcw_pkg::CLEAR_CELL;
				scan_d    = scan_q + tcw_pkg::SCAN_W'(1);
				if (scan_q == tcw_pkg::SCAN_W'(tcw_pkg::CELLS - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE, tcw_pkg::ST_FINISH: begin
				if (start) begin
					item_d  = item;
					state_d = tcw_pkg::ST_EXEC;
				end else begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_EXEC: begin
				scrolled_d = 1'b0;
				cell_ok_d  = 1'b0;
				state_d    = tcw_pkg::ST_FINISH;
				if (item_q.opcode == tcw_pkg::OP_READ) begin
					ram_re    = 1'b1;
					ram_raddr = tcw_pkg::cell_addr(item_q.read_row, item_q.read_col);
					cell_ok_d = rd_in_range;
				end else if (item_q.char_code == tcw_pkg::NEWLINE_CODE) begin
					new_row = 1'b1;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = tcw_pkg::cell_addr(cur_row_q, cur_col_q);
					ram_wdata = {color_q, item_q.char_code};
					if (col_wrap) begin
						new_row = 1'b1;
					end else begin
						cur_col_d = col_next[tcw_pkg::COL_W-1:0];
					end
				end
				if (new_row) begin
					cur_col_d = '0;
					if (at_bottom) begin
						scrolled_d = 1'b1;
						scan_d     = '0;
						pend_d     = 1'b0;
						state_d    = tcw_pkg::ST_SCROLL;
					end else begin
						cur_row_d = cur_row_q + tcw_pkg::ROW_W'(1);
					end
				end
			end
			tcw_pkg::ST_SCROLL: begin
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = pend_addr_q;
					ram_wdata = pend_zero_q ? '0 : ram_rdata;
				end
				if (scan_q == tcw_pkg::SCAN_W'(tcw_pkg::CELLS)) begin
					pend_d  = 1'b0;
					state_d = tcw_pkg::ST_FINISH;
				end else begin
					pend_d      = 1'b1;
					pend_addr_d = scan_q[tcw_pkg::ADDR_W-1:0];
					pend_zero_d = scan_q >= tcw_pkg::SCAN_W'(tcw_pkg::LAST_BASE);
					if (scan_q < tcw_pkg::SCAN_W'(tcw_pkg::LAST_BASE)) begin
						ram_re    = 1'b1;
						ram_raddr = src_scan[tcw_pkg::ADDR_W-1:0];
					end
					scan_d = scan_q + tcw_pkg::SCAN_W'(1);
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcw_pkg::ST_CLEAR;
			cur_row_q <= '0;
			cur_col_q <= '0;
			color_q   <= tcw_pkg::RESET_COLOR;
			scan_q    <= '0;
			pend_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			scan_q    <= scan_d;
			pend_q    <= pend_d;
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q      <= item_d;
		pend_zero_q <= pend_zero_d;
		pend_addr_q <= pend_addr_d;
		scrolled_q  <= scrolled_d;
		cell_ok_q   <= cell_ok_d;
	end

	assign busy      = !(state_q == tcw_pkg::ST_IDLE || state_q == tcw_pkg::ST_FINISH);
	assign done      = state_q == tcw_pkg::ST_FINISH;
	assign cfg_ready = 1'b1;

	always_comb begin
		result.cell_char  = cell_ok_q ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
		result.cell_attr  = cell_ok_q ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
		result.cursor_row = cur_row_q;
		result.cursor_col = cur_col_q;
		result.scrolled   = scrolled_q;
		result.write_done = item_q.end_of_string;
	end

endmodule

FILE: src/tcw_checker.sv
`include "assert_macros.svh"

module tcw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input tcw_pkg::result_t result
);

	`TCW_ASSERT(a_accept_busy, clk, arst_n, start && !busy |=> busy, "accepted transaction did not raise busy")
	`TCW_ASSERT(a_done_single, clk, arst_n, done |=> !done, "done held for more than one cycle")
	`TCW_NEVER(a_done_not_busy, clk, arst_n, done && busy, "done while busy")
	`TCW_ASSERT(a_cursor_range, clk, arst_n, done |-> (32'(result.cursor_col) < tcw_pkg::COLUMNS) && (32'(result.cursor_row) < tcw_pkg::ROWS), "cursor out of screen")
	`TCW_ASSERT(a_scroll_bottom, clk, arst_n, done && result.scrolled |-> 32'(result.cursor_row) == tcw_pkg::ROWS - 1, "scroll left cursor off bottom row")

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
